// ----- hw/rtl/swm_pkg.sv -----
`timescale 1ns / 1ps

package swm_pkg;

   // Sizes of the sample path and of the cell row
   localparam int SAMPLE_BITS = 16;
   localparam int WINDOW_MAX  = 64;
   localparam int LEN_BITS    = 7;
   localparam int AGE_BITS    = 7;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic [LEN_BITS-1:0]           len_type;
   typedef logic [AGE_BITS-1:0]           age_type;

   localparam len_type WINDOW_RESET = len_type'(3);
   localparam len_type WINDOW_TOP   = len_type'(WINDOW_MAX);

   // Per-beat control shared by every cell
   typedef struct packed {
      logic step;     // a sample beat is taken this cycle
      logic restart;  // the beat starts a new sequence
      logic drop;     // the front candidate leaves the window
      logic clear;    // register write: empty the row
   } swm_ctl_type;

   // What a cell shows its neighbors
   typedef struct packed {
      logic       valid;
      logic       keep;   // survives the new sample
      sample_type value;
      age_type    age;    // beats since the candidate entered
   } swm_link_type;

   // Window length as used: zero acts as one, large values clamp
   function automatic len_type eff_length(input len_type wl);
      len_type k;
      k = wl;
      if (wl == len_type'(0)) begin
         k = len_type'(1);
      end else if (wl > WINDOW_TOP) begin
         k = WINDOW_TOP;
      end
      return k;
   endfunction

endpackage

// ----- hw/rtl/swm_if.sv -----
`timescale 1ns / 1ps

// Sample channel
interface swm_req_if;
   import swm_pkg::*;
   logic       valid;
   logic       ready;
   sample_type sample;
   logic       restart;

   modport source (output valid, output sample, output restart, input ready);
   modport sink   (input valid, input sample, input restart, output ready);
endinterface

// Result channel
interface swm_rsp_if;
   import swm_pkg::*;
   logic       valid;
   logic       ready;
   sample_type window_max;

   modport source (output valid, output window_max, input ready);
   modport sink   (input valid, input window_max, output ready);
endinterface

// Window length register write channel
interface swm_csr_if;
   import swm_pkg::*;
   logic    valid;
   logic    ready;
   len_type window_length;

   modport source (output valid, output window_length, input ready);
   modport sink   (input valid, input window_length, output ready);
endinterface

// ----- hw/rtl/swm_cell.sv -----
`timescale 1ns / 1ps

// One slot of the monotonic candidate queue. Slot 0 is the front.
module swm_cell import swm_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  swm_ctl_type  ctl,
   input  sample_type   sample,
   input  logic         head,      // this is the front slot
   input  logic         prv_keep,  // left neighbor survives
   input  swm_link_type nxt,       // right neighbor
   output swm_link_type own,
   output sample_type   value_in
);

   logic       valid_ff, valid_in;
   sample_type value_ff;
   age_type    age_ff, age_in;
   logic       keep;

   // A valid candidate survives unless the new sample is strictly larger or the beat is a restart
   assign keep = valid_ff && !ctl.restart && (value_ff >= sample);

   assign own = '{valid: valid_ff, keep: keep, value: value_ff, age: age_ff};

   // Next slot contents: hold, empty, shift in from the right, or take the new sample
   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      age_in   = age_ff;
      if (ctl.clear) begin
         valid_in = 1'b0;
      end else if (ctl.step) begin
         if (ctl.drop) begin
            if (nxt.keep) begin
               valid_in = 1'b1;
               value_in = nxt.value;
               age_in   = nxt.age + 1'b1;
            end else if (keep || head) begin
               valid_in = 1'b1;
               value_in = sample;
               age_in   = age_type'(1);
            end else begin
               valid_in = 1'b0;
            end
         end else begin
            if (keep) begin
               age_in = age_ff + 1'b1;
            end else if (prv_keep) begin
               valid_in = 1'b1;
               value_in = sample;
               age_in   = age_type'(1);
            end else begin
               valid_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      age_ff   <= age_in;
   end

endmodule

// ----- hw/rtl/sliding_window_maximum.sv -----
`timescale 1ns / 1ps
// A result beat is registered and appears in the cycle after the sample beat that causes it.
// Throughput: one sample beat per cycle while the result is not stalled; the whole cell row updates in that cycle.
// A sample yields a result only once eff_length(window_length) samples of the sequence are in.
// Reset: window_length goes to 3, the candidate row and sample count are emptied.
// A window_length write also empties them; a restart sample replaces them with itself alone.

module sliding_window_maximum import swm_pkg::*; (
   input logic       clock,
   input logic       reset,
   swm_req_if.sink   req_if,
   swm_rsp_if.source rsp_if,
   swm_csr_if.sink   csr_if
);

   len_type      window_length_ff;
   len_type      k;
   len_type      seen_ff, seen_in, seen_cur, seen_step;
   logic         rsp_valid_ff, rsp_valid_in;
   sample_type   window_max_ff;
   logic         step, csr_write, emit;
   swm_ctl_type  ctl;
   swm_link_type link [WINDOW_MAX+1];
   sample_type   value_nxt [WINDOW_MAX];

   assign k         = eff_length(window_length_ff);
   assign step      = req_if.valid && req_if.ready;
   assign csr_write = csr_if.valid && csr_if.ready;

   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign csr_if.ready = 1'b1;
   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.window_max = window_max_ff;

   // Sample count of the current sequence, saturating at the window length
   always_comb begin
      seen_cur  = req_if.restart ? len_type'(0) : seen_ff;
      seen_step = (seen_cur < k) ? seen_cur + 1'b1 : seen_cur;
      seen_in   = seen_ff;
      if (csr_write) begin
         seen_in = len_type'(0);
      end else if (step) begin
         seen_in = seen_step;
      end
   end

   assign emit = step && (seen_step >= k);

   // Front leaves when it entered exactly one window length ago
   always_comb begin
      ctl.step    = step;
      ctl.restart = req_if.restart;
      ctl.clear   = csr_write;
      ctl.drop    = !req_if.restart && link[0].valid && (link[0].age == k)
                    && (seen_ff >= k);
   end

   // Candidate row
   assign link[WINDOW_MAX] = '0;
   for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
      logic prv_keep;
      if (i == 0) begin : g_head
         assign prv_keep = 1'b1;
      end else begin : g_body
         assign prv_keep = link[i-1].keep;
      end
      swm_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl),
         .sample   (req_if.sample),
         .head     (i == 0),
         .prv_keep (prv_keep),
         .nxt      (link[i+1]),
         .own      (link[i]),
         .value_in (value_nxt[i])
      );
   end

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_length_ff <= WINDOW_RESET;
         seen_ff          <= len_type'(0);
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_write) begin
            window_length_ff <= csr_if.window_length;
         end
         seen_ff      <= seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         window_max_ff <= value_nxt[0];
      end
   end

endmodule

// ----- hw/rtl/swm_checker.sv -----
`timescale 1ns / 1ps

module swm_checker import swm_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input sample_type req_sample,
   input logic       req_restart,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input sample_type rsp_window_max,
   input logic       csr_valid,
   input logic       csr_ready,
   input len_type    csr_window_length
);

   len_type wl_ff;
   logic    req_beat, k_one;

   assign req_beat = req_valid && req_ready;
   assign k_one    = (wl_ff == len_type'(0)) || (wl_ff == len_type'(1));

   // Shadow of the window length register
   always_ff @(posedge clock) begin
      if (reset) begin
         wl_ff <= WINDOW_RESET;
      end else if (csr_valid && csr_ready) begin
         wl_ff <= csr_window_length;
      end
   end

   // No result right after reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat after reset");

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_window_max))
      else $error("stalled result changed");

   // A restart sample cannot fill a window longer than one
   a_restart_quiet: assert property (@(posedge clock) disable iff (reset)
      req_beat && req_restart && !k_one |=> !rsp_valid)
      else $error("result on restart with window above one");

   // With a window of one the result is the sample itself
   a_unit_window: assert property (@(posedge clock) disable iff (reset)
      req_beat && k_one |=> rsp_valid && (rsp_window_max == $past(req_sample)))
      else $error("window of one does not pass the sample");

endmodule

bind sliding_window_maximum swm_checker u_swm_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_if.valid),
   .req_ready         (req_if.ready),
   .req_sample        (req_if.sample),
   .req_restart       (req_if.restart),
   .rsp_valid         (rsp_if.valid),
   .rsp_ready         (rsp_if.ready),
   .rsp_window_max    (rsp_if.window_max),
   .csr_valid         (csr_if.valid),
   .csr_ready         (csr_if.ready),
   .csr_window_length (csr_if.window_length)
);
